### rtl/lcsm_pkg.sv
// ============================================================================
// lcsm_pkg
// Shared types and constants for the label centroid sphere marker.
// ============================================================================
package lcsm_pkg;

    localparam int COORD_W  = 6;
    localparam int LABEL_W  = 8;
    localparam int KIND_W   = 2;
    localparam int RADIUS_W = 6;
    localparam int SUM_W    = 24;
    localparam int CNT_W    = 19;
    localparam int SQ_W     = 2 * COORD_W;
    localparam int DIST_W   = SQ_W + 2;

    // divider: numerator 2*sum+n, denominator 2*n
    localparam int NUM_W  = SUM_W + 2;
    localparam int DEN_W  = CNT_W + 1;
    localparam int REM_W  = DEN_W + 1;
    localparam int STEP_W = $clog2(NUM_W);

    // voxel store, addressed x + 64*y + 4096*z
    localparam int ADDR_W      = 3 * COORD_W;
    localparam int STORE_DEPTH = 1 << ADDR_W;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_TARGET = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 1'b1;

    localparam logic [KIND_W-1:0] KIND_LOAD = 2'd0;
    localparam logic [KIND_W-1:0] KIND_READ = 2'd1;
    localparam logic [KIND_W-1:0] KIND_NEW  = 2'd2;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    localparam logic [LABEL_W-1:0]  TARGET_RST = 8'd1;
    localparam logic [RADIUS_W-1:0] RADIUS_RST = 6'd4;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [COORD_W-1:0] pos_x;
        logic [COORD_W-1:0] pos_y;
        logic [COORD_W-1:0] pos_z;
        logic [LABEL_W-1:0] label_in;
    } in_word_t;

    typedef struct packed {
        logic [LABEL_W-1:0] label_out;
        logic               target_present;
    } out_word_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_SQ,
        ST_RES
    } state_t;

endpackage

### rtl/label_centroid_sphere_marker_core.sv
// ============================================================================
// label_centroid_sphere_marker_core
// Label volume store that paints a sphere at the target label's centroid.
// ============================================================================
// Load words write one voxel into the 64x64x64 store (addressed x + 64*y +
// 4096*z) and, when the label equals target_label, add the position to the
// running sums; load and new-volume words stream at one word per clock
// while no read is in progress. Positions at or beyond DIM_X/DIM_Y/DIM_Z
// are not stored, and read back as 0. A read word passes through the store
// read issued at acceptance, the squared-distance stage and the result
// stage. The first read after any load or new-volume word, with target
// voxels counted, also fixes the centroid, rounded as floor((2*sum+n)/(2n))
// and clamped to 63, on the shared bit-serial divider: per axis a start,
// the bit steps and a capture, one axis after another. With no target voxel counted the
// centroid is the origin and no divide runs. Result words sit in an output
// register, so loads are still taken while a result waits for m_ready. With
// no target voxel loaded nothing is painted. Configuration writes are always
// ready; change them only when the block is idle.
module label_centroid_sphere_marker_core
    import lcsm_pkg::*;
#(
    parameter int DIM_X = 64,
    parameter int DIM_Y = 64,
    parameter int DIM_Z = 64
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // input words
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_word_t              s_data,
    // result words
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_word_t             m_data,
    // register writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    state_t               state_reg, state_next;
    logic [LABEL_W-1:0]   target_reg;
    logic [RADIUS_W-1:0]  radius_reg;

    logic [SUM_W-1:0]     sum_x_reg, sum_x_next;
    logic [SUM_W-1:0]     sum_y_reg, sum_y_next;
    logic [SUM_W-1:0]     sum_z_reg, sum_z_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [COORD_W-1:0]   center_reg [0:2];
    logic                 center_ready_reg, center_ready_next;
    logic [1:0]           axis_reg, axis_next;

    // captured read position
    logic [COORD_W-1:0]   rd_x_reg, rd_y_reg, rd_z_reg;
    logic                 rd_in_vol_reg;

    // squared terms
    logic [SQ_W-1:0]      sq_x_reg, sq_y_reg, sq_z_reg, r_sq_reg;

    logic                 m_valid_reg, m_valid_next;
    out_word_t            m_data_reg;

    // ------------------------------------------------------------------
    // Input decode
    // ------------------------------------------------------------------
    logic                 s_acc;
    logic                 in_vol;
    logic                 load_acc, read_acc, new_acc;
    logic                 ram_we, match;
    logic [ADDR_W-1:0]    s_addr;
    logic [LABEL_W-1:0]   stored;

    assign s_acc    = s_valid && s_ready;
    assign in_vol   = (int'(s_data.pos_x) < DIM_X) && (int'(s_data.pos_y) < DIM_Y)
                   && (int'(s_data.pos_z) < DIM_Z);
    assign load_acc = s_acc && (s_data.kind == KIND_LOAD);
    assign read_acc = s_acc && (s_data.kind == KIND_READ);
    assign new_acc  = s_acc && (s_data.kind == KIND_NEW);
    assign ram_we   = load_acc && in_vol;
    assign match    = ram_we && (s_data.label_in == target_reg);
    assign s_addr   = {s_data.pos_z, s_data.pos_y, s_data.pos_x};

    // store: written by loads, read once per read word at acceptance;
    // the read data holds until the next read, which cannot come before
    // the result stage
    lcsm_ram #(
        .WIDTH (LABEL_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .aclk    (aclk),
        .we      (ram_we),
        .wr_addr (s_addr),
        .wr_data (s_data.label_in),
        .rd_en   (read_acc),
        .rd_addr (s_addr),
        .rd_data (stored)
    );

    // ------------------------------------------------------------------
    // Centroid divider, shared over the three axes
    // ------------------------------------------------------------------
    logic                 div_start;
    logic                 div_done;
    logic [COORD_W-1:0]   div_quot;
    logic [SUM_W-1:0]     sum_sel;
    logic [NUM_W-1:0]     div_num;
    logic [DEN_W-1:0]     div_den;

    always_comb begin
        case (axis_reg)
            AXIS_X:  sum_sel = sum_x_reg;
            AXIS_Y:  sum_sel = sum_y_reg;
            default: sum_sel = sum_z_reg;
        endcase
    end

    assign div_num = {1'b0, sum_sel, 1'b0} + NUM_W'(count_reg);
    assign div_den = {count_reg, 1'b0};

    lcsm_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .num      (div_num),
        .den      (div_den),
        .done     (div_done),
        .quot_sat (div_quot)
    );

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    logic out_free;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (read_acc) begin
                    if (!center_ready_reg && (count_reg != '0)) begin
                        state_next = ST_DIV_START;
                    end else begin
                        state_next = ST_SQ;
                    end
                end
            end
            ST_DIV_START: state_next = ST_DIV_WAIT;
            ST_DIV_WAIT: begin
                if (div_done) begin
                    state_next = (axis_reg == AXIS_Z) ? ST_SQ : ST_DIV_START;
                end
            end
            ST_SQ: state_next = ST_RES;
            ST_RES: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Outputs of the sequencer
    // ------------------------------------------------------------------
    always_comb begin
        s_ready   = 1'b0;
        div_start = 1'b0;
        case (state_reg)
            ST_IDLE:      s_ready   = 1'b1;
            ST_DIV_START: div_start = 1'b1;
            default: begin
                s_ready   = 1'b0;
                div_start = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Sums, count and centroid bookkeeping
    // ------------------------------------------------------------------
    always_comb begin
        sum_x_next        = sum_x_reg;
        sum_y_next        = sum_y_reg;
        sum_z_next        = sum_z_reg;
        count_next        = count_reg;
        center_ready_next = center_ready_reg;
        axis_next         = axis_reg;
        if (new_acc) begin
            sum_x_next        = '0;
            sum_y_next        = '0;
            sum_z_next        = '0;
            count_next        = '0;
            center_ready_next = 1'b0;
        end else if (load_acc) begin
            center_ready_next = 1'b0;
            if (match) begin
                sum_x_next = sum_x_reg + SUM_W'(s_data.pos_x);
                sum_y_next = sum_y_reg + SUM_W'(s_data.pos_y);
                sum_z_next = sum_z_reg + SUM_W'(s_data.pos_z);
                count_next = count_reg + 1'b1;
            end
        end else if (read_acc) begin
            axis_next = AXIS_X;
            // empty target: centroid is the origin, nothing to divide
            if (!center_ready_reg && (count_reg == '0)) begin
                center_ready_next = 1'b1;
            end
        end else if ((state_reg == ST_DIV_WAIT) && div_done) begin
            if (axis_reg == AXIS_Z) begin
                center_ready_next = 1'b1;
            end else begin
                axis_next = axis_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            target_reg       <= TARGET_RST;
            radius_reg       <= RADIUS_RST;
            sum_x_reg        <= '0;
            sum_y_reg        <= '0;
            sum_z_reg        <= '0;
            count_reg        <= '0;
            center_reg[0]    <= '0;
            center_reg[1]    <= '0;
            center_reg[2]    <= '0;
            center_ready_reg <= 1'b0;
            axis_reg         <= AXIS_X;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg        <= state_next;
            sum_x_reg        <= sum_x_next;
            sum_y_reg        <= sum_y_next;
            sum_z_reg        <= sum_z_next;
            count_reg        <= count_next;
            center_ready_reg <= center_ready_next;
            axis_reg         <= axis_next;
            m_valid_reg      <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_TARGET: target_reg <= cfg_data[LABEL_W-1:0];
                    CFG_RADIUS: radius_reg <= cfg_data[RADIUS_W-1:0];
                    default:    target_reg <= target_reg;
                endcase
            end
            if (read_acc && !center_ready_reg && (count_reg == '0)) begin
                center_reg[0] <= '0;
                center_reg[1] <= '0;
                center_reg[2] <= '0;
            end else if ((state_reg == ST_DIV_WAIT) && div_done) begin
                center_reg[axis_reg] <= div_quot;
            end
        end
    end

    assign cfg_ready = 1'b1;

    // ------------------------------------------------------------------
    // Read datapath: capture, squares, compare
    // ------------------------------------------------------------------
    logic [COORD_W-1:0] dx, dy, dz;
    logic [DIST_W-1:0]  dist_sq;
    logic               in_sphere;
    logic [LABEL_W-1:0] label_res;

    assign dx = (rd_x_reg > center_reg[0]) ? rd_x_reg - center_reg[0]
                                           : center_reg[0] - rd_x_reg;
    assign dy = (rd_y_reg > center_reg[1]) ? rd_y_reg - center_reg[1]
                                           : center_reg[1] - rd_y_reg;
    assign dz = (rd_z_reg > center_reg[2]) ? rd_z_reg - center_reg[2]
                                           : center_reg[2] - rd_z_reg;

    assign dist_sq   = DIST_W'(sq_x_reg) + DIST_W'(sq_y_reg) + DIST_W'(sq_z_reg);
    assign in_sphere = (count_reg != '0) && (dist_sq <= DIST_W'(r_sq_reg));

    always_comb begin
        if (!rd_in_vol_reg) begin
            label_res = '0;
        end else if (in_sphere) begin
            label_res = target_reg;
        end else if (stored == target_reg) begin
            label_res = '0;
        end else begin
            label_res = stored;
        end
    end

    always_ff @(posedge aclk) begin
        if (read_acc) begin
            rd_x_reg      <= s_data.pos_x;
            rd_y_reg      <= s_data.pos_y;
            rd_z_reg      <= s_data.pos_z;
            rd_in_vol_reg <= in_vol;
        end
        if (state_reg == ST_SQ) begin
            sq_x_reg <= dx * dx;
            sq_y_reg <= dy * dy;
            sq_z_reg <= dz * dz;
            r_sq_reg <= radius_reg * radius_reg;
        end
        if ((state_reg == ST_RES) && out_free) begin
            m_data_reg.label_out      <= label_res;
            m_data_reg.target_present <= (count_reg != '0);
        end
    end

    // output register
    always_comb begin
        m_valid_next = m_valid_reg;
        if ((state_reg == ST_RES) && out_free) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_store_write_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == ST_IDLE))
        else $error("store written while a read is in progress");

    a_read_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        read_acc |=> (state_reg != ST_IDLE))
        else $error("read word accepted without starting its sequence");

    a_div_done_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_DIV_WAIT))
        else $error("divider finished outside its wait state");

    a_empty_origin: assert property (@(posedge aclk) disable iff (!aresetn)
        (center_ready_reg && (count_reg == '0)) |->
            ((center_reg[0] == '0) && (center_reg[1] == '0) && (center_reg[2] == '0)))
        else $error("centroid not at origin for an absent target");

endmodule

### rtl/lcsm_ram.sv
// ============================================================================
// lcsm_ram
// Generic single-clock RAM, one write port, one read port, registered read.
// ============================================================================
module lcsm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/lcsm_div.sv
// ============================================================================
// lcsm_div
// Restoring divider, one quotient bit per cycle; quotient saturated to 63.
// ============================================================================
module lcsm_div
    import lcsm_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [NUM_W-1:0]   num,
    input  logic [DEN_W-1:0]   den,
    output logic               done,
    output logic [COORD_W-1:0] quot_sat
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [DEN_W-1:0]  rem_reg,  rem_next;
    logic [NUM_W-1:0]  quo_reg,  quo_next;
    logic [DEN_W-1:0]  den_reg,  den_next;

    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  rem_sub;
    logic              ge;

    assign rem_sh  = {rem_reg, quo_reg[NUM_W-1]};
    assign ge      = rem_sh >= {1'b0, den_reg};
    assign rem_sub = rem_sh - {1'b0, den_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        if (start) begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = '0;
            quo_next  = num;
            den_next  = den;
        end else if (busy_reg) begin
            // remainder stays below den, so it fits back in DEN_W bits
            rem_next  = ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
            quo_next  = {quo_reg[NUM_W-2:0], ge};
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(NUM_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign done     = done_reg;
    assign quot_sat = (|quo_reg[NUM_W-1:COORD_W]) ? '1 : quo_reg[COORD_W-1:0];

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for label_centroid_sphere_marker_core.
// Voxel loads, reads and new-volume words are streamed in and every read
// result is checked against a behavioural copy of the block. The copy holds
// its own voxel store, centroid sums and register settings. The run covers
// several register settings, sender and receiver stalls, and one long
// receiver hold that backs the block up.
// ----------------------------------------------------------------------------
module testbench;
    import lcsm_pkg::*;

    // spare kind code, the block must swallow it without a result
    localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

    localparam int VOL_DIM        = 64;
    localparam int SETTLE_CYC     = 120;    // covers a read and its centroid divide
    localparam int HOLD_CYC       = 400;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int RAND_PER_PHASE = 75;
    localparam int NUM_PHASES     = 6;

    // ------------------------------------------------------------------------
    // Behavioural copy of the marker: store, sums, centroid and the queue of
    // labels that reads are due to return.
    // ------------------------------------------------------------------------
    class centroid_paint_board;
        bit [LABEL_W-1:0]  voxels [STORE_DEPTH];
        bit [LABEL_W-1:0]  target;
        bit [RADIUS_W-1:0] radius;
        bit [SUM_W-1:0]    sum_x, sum_y, sum_z;
        bit [CNT_W-1:0]    hits;
        bit [COORD_W-1:0]  cen_x, cen_y, cen_z;
        bit                cen_fixed;
        out_word_t         painted_q[$];
        int                errors;

        function new();
            target = TARGET_RST;
            radius = RADIUS_RST;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_TARGET) begin
                target = data[LABEL_W-1:0];
            end else begin
                radius = data[RADIUS_W-1:0];
            end
        endfunction

        // floor((2*sum + n) / (2*n)), clamped to the top coordinate
        function bit [COORD_W-1:0] rounded_mean(bit [SUM_W-1:0] s, bit [CNT_W-1:0] n);
            longint q;
            q = (2 * longint'(s) + longint'(n)) / (2 * longint'(n));
            return (q > 63) ? 6'd63 : q[COORD_W-1:0];
        endfunction

        function int axis_sq(bit [COORD_W-1:0] a, bit [COORD_W-1:0] b);
            int d;
            d = int'(a) - int'(b);
            return d * d;
        endfunction

        function void note_word(in_word_t w);
            bit [ADDR_W-1:0] addr;
            bit              in_vol;
            out_word_t       res;
            int              dist_sq;
            addr   = {w.pos_z, w.pos_y, w.pos_x};
            in_vol = (w.pos_x < VOL_DIM) && (w.pos_y < VOL_DIM) && (w.pos_z < VOL_DIM);
            case (w.kind)
                KIND_LOAD: begin
                    cen_fixed = 1'b0;
                    if (in_vol) begin
                        voxels[addr] = w.label_in;
                        if (w.label_in == target) begin
                            sum_x += w.pos_x;
                            sum_y += w.pos_y;
                            sum_z += w.pos_z;
                            hits  += 1'b1;
                        end
                    end
                end
                KIND_NEW: begin
                    sum_x     = '0;
                    sum_y     = '0;
                    sum_z     = '0;
                    hits      = '0;
                    cen_fixed = 1'b0;
                end
                KIND_READ: begin
                    if (!cen_fixed) begin
                        if (hits != 0) begin
                            cen_x = rounded_mean(sum_x, hits);
                            cen_y = rounded_mean(sum_y, hits);
                            cen_z = rounded_mean(sum_z, hits);
                        end else begin
                            cen_x = '0;
                            cen_y = '0;
                            cen_z = '0;
                        end
                        cen_fixed = 1'b1;
                    end
                    res.label_out = '0;
                    if (in_vol) begin
                        dist_sq = axis_sq(w.pos_x, cen_x) + axis_sq(w.pos_y, cen_y)
                                + axis_sq(w.pos_z, cen_z);
                        if (hits != 0 && dist_sq <= int'(radius) * int'(radius)) begin
                            res.label_out = target;
                        end else if (voxels[addr] == target) begin
                            res.label_out = '0;
                        end else begin
                            res.label_out = voxels[addr];
                        end
                    end
                    res.target_present = (hits != 0);
                    painted_q.push_back(res);
                end
                default: ;
            endcase
        endfunction

        function void check_word(out_word_t got);
            out_word_t want;
            if (painted_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result word, label_out %0d target_present %0b",
                         $time, got.label_out, got.target_present);
                return;
            end
            want = painted_q.pop_front();
            if (got.label_out !== want.label_out) begin
                errors++;
                $display("%0t: label_out mismatch, expected %0d actual %0d",
                         $time, want.label_out, got.label_out);
            end
            if (got.target_present !== want.target_present) begin
                errors++;
                $display("%0t: target_present mismatch, expected %0b actual %0b",
                         $time, want.target_present, got.target_present);
            end
        endfunction

        function int pending();
            return painted_q.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT hook-up; every input has a known value from time zero
    // ------------------------------------------------------------------------
    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    in_word_t              s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    out_word_t             m_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_TARGET;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    centroid_paint_board paint_board = new();

    int  send_idle_pct = 14;
    int  recv_idle_pct = 52;
    bit  hold_req      = 1'b0;   // asks the sink for one long hold-off
    int  cycles        = 0;
    int  items_sent    = 0;      // words the block acts on; spare kinds excluded

    // voxels written so far, so that reads never touch an unwritten entry
    bit [ADDR_W-1:0] loaded_q[$];
    bit              loaded_map [STORE_DEPTH];

    label_centroid_sphere_marker_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // run-away guard
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // result monitor: sampled at the rising edge, inputs move on the falling one
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            paint_board.check_word(m_data);
        end
    end

    // result sink: random stalls, plus one long hold-off when asked so the
    // output register fills and the block has to refuse read words
    initial begin : result_sink
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYC) @(negedge aclk);
                hold_req = 1'b0;
            end
            m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Word builders and drivers
    // ------------------------------------------------------------------------
    function automatic in_word_t make_word(input logic [KIND_W-1:0]  kind,
                                           input logic [COORD_W-1:0] x,
                                           input logic [COORD_W-1:0] y,
                                           input logic [COORD_W-1:0] z,
                                           input logic [LABEL_W-1:0] lab);
        in_word_t w;
        w.kind     = kind;
        w.pos_x    = x;
        w.pos_y    = y;
        w.pos_z    = z;
        w.label_in = lab;
        return w;
    endfunction

    // random coordinate within spread of c, clipped to the volume
    function automatic bit [COORD_W-1:0] near(input bit [COORD_W-1:0] c, input int spread);
        int v;
        v = int'(c) + int'($urandom_range(0, 2 * spread)) - spread;
        if (v < 0) v = 0;
        if (v > VOL_DIM - 1) v = VOL_DIM - 1;
        return v[COORD_W-1:0];
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance;
    // valid is left high so back-to-back words need no second assignment
    task automatic send_word(input in_word_t w);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        paint_board.note_word(w);
        if (w.kind != KIND_SPARE) items_sent++;
        @(negedge aclk);
    endtask

    task automatic load_voxel(input bit [COORD_W-1:0] x, input bit [COORD_W-1:0] y,
                              input bit [COORD_W-1:0] z, input bit [LABEL_W-1:0] lab);
        bit [ADDR_W-1:0] addr;
        addr = {z, y, x};
        send_word(make_word(KIND_LOAD, x, y, z, lab));
        if (!loaded_map[addr]) begin
            loaded_map[addr] = 1'b1;
            loaded_q.push_back(addr);
        end
    endtask

    task automatic read_voxel(input bit [COORD_W-1:0] x, input bit [COORD_W-1:0] y,
                              input bit [COORD_W-1:0] z);
        send_word(make_word(KIND_READ, x, y, z, LABEL_W'($urandom)));
    endtask

    // read a voxel already written; recent leans on the last few dozen loads
    task automatic read_known(input bit recent);
        int              n;
        int              idx;
        bit [ADDR_W-1:0] addr;
        n = loaded_q.size();
        if (n == 0) return;
        if (recent) begin
            idx = n - 1 - int'($urandom_range(0, (n > 32) ? 31 : n - 1));
        end else begin
            idx = $urandom_range(0, n - 1);
        end
        addr = loaded_q[idx];
        read_voxel(addr[COORD_W-1:0], addr[2*COORD_W-1:COORD_W], addr[ADDR_W-1:2*COORD_W]);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        paint_board.write_reg(idx, data);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    // let every pending read come back, then wait out the settle time
    task automatic settle();
        s_valid <= 1'b0;
        while (paint_board.pending() != 0) @(negedge aclk);
        repeat (SETTLE_CYC) @(negedge aclk);
    endtask

    // ------------------------------------------------------------------------
    // Directed words at reset register values (target 1, radius 4)
    // ------------------------------------------------------------------------
    task automatic directed_items();
        load_voxel(0, 0, 0, 8'd0);
        load_voxel(63, 63, 63, 8'd255);
        load_voxel(5, 5, 5, TARGET_RST);
        // new volume: sums cleared, store kept; random-looking unused fields
        send_word(make_word(KIND_NEW, 6'd63, 6'd0, 6'd63, 8'd255));
        // no target counted: stored target reads 0, other labels pass through
        read_voxel(5, 5, 5);
        read_voxel(63, 63, 63);
        read_voxel(0, 0, 0);
        // spare kind carries a target label but must change nothing
        send_word(make_word(KIND_SPARE, 6'd1, 6'd2, 6'd3, TARGET_RST));
        // small target cluster, centroid rounds to (10,11,10)
        load_voxel(10, 10, 10, TARGET_RST);
        load_voxel(11, 10, 10, TARGET_RST);
        load_voxel(10, 12, 10, TARGET_RST);
        read_voxel(10, 10, 10);
        read_voxel(5, 5, 5);        // target voxel outside the sphere
        read_voxel(63, 63, 63);
        // load after reads moves the centroid
        load_voxel(20, 10, 10, TARGET_RST);
        read_voxel(11, 10, 10);
        load_voxel(42, 21, 0, 8'h2A);
        load_voxel(21, 42, 63, 8'h55);
        read_voxel(42, 21, 0);
        read_voxel(21, 42, 63);
        // same voxel loaded twice is counted twice
        load_voxel(10, 10, 10, TARGET_RST);
        read_voxel(10, 12, 10);
        // overwrite with another label, count stays
        load_voxel(10, 10, 10, 8'd200);
        read_voxel(10, 10, 10);
    endtask

    // ------------------------------------------------------------------------
    // Random traffic
    // ------------------------------------------------------------------------
    // a volume-shaped burst: maybe a fresh volume, a cluster of loads around a
    // random point, then reads mostly of the cluster with the odd stray load
    task automatic blob_sequence();
        bit [COORD_W-1:0] cx, cy, cz;
        bit [LABEL_W-1:0] lab;
        int               spread;
        int               n_load;
        int               n_read;
        if ($urandom_range(0, 9) < 7) begin
            send_word(make_word(KIND_NEW, COORD_W'($urandom), COORD_W'($urandom),
                                COORD_W'($urandom), LABEL_W'($urandom)));
        end
        cx     = COORD_W'($urandom);
        cy     = COORD_W'($urandom);
        cz     = COORD_W'($urandom);
        spread = $urandom_range(1, 8);
        n_load = $urandom_range(3, 16);
        n_read = $urandom_range(2, 8);
        repeat (n_load) begin
            lab = ($urandom_range(0, 9) < 6) ? paint_board.target : LABEL_W'($urandom);
            load_voxel(near(cx, spread), near(cy, spread), near(cz, spread), lab);
        end
        repeat (n_read) begin
            if ($urandom_range(0, 9) < 2) begin
                lab = ($urandom_range(0, 1) != 0) ? paint_board.target : LABEL_W'($urandom);
                load_voxel(near(cx, spread), near(cy, spread), near(cz, spread), lab);
            end
            read_known($urandom_range(0, 9) < 8);
        end
    endtask

    task automatic noise_item();
        case ($urandom_range(0, 4))
            0: send_word(make_word(KIND_SPARE, COORD_W'($urandom), COORD_W'($urandom),
                                   COORD_W'($urandom), LABEL_W'($urandom)));
            1: send_word(make_word(KIND_NEW, COORD_W'($urandom), COORD_W'($urandom),
                                   COORD_W'($urandom), LABEL_W'($urandom)));
            2: load_voxel(COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
                          LABEL_W'($urandom));
            default: read_known(1'b0);
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        bit [LABEL_W-1:0]  tgt;
        bit [RADIUS_W-1:0] rad;
        int                goal;
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        directed_items();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            // registers only change with the block drained; sums carry over,
            // so a new target meets sums gathered under the old one
            if (ph > 0) begin
                settle();
                case (ph)
                    1: begin tgt = 8'd255; rad = 6'd63; end
                    2: begin tgt = 8'd0;   rad = 6'd0;  end
                    4: begin
                        tgt = LABEL_W'($urandom);
                        rad = RADIUS_W'($urandom_range(1, 6));
                    end
                    default: begin
                        tgt = LABEL_W'($urandom);
                        rad = RADIUS_W'($urandom);
                    end
                endcase
                write_reg(CFG_TARGET, tgt);
                // upper data bits are don't-care for the radius
                write_reg(CFG_RADIUS, {2'($urandom), rad});
            end
            send_idle_pct = (ph < 2) ? 14 : (ph < 4) ? 52 : 0;
            recv_idle_pct = (ph < 2) ? 52 : (ph < 4) ? 14 : 0;
            if (ph == 1) hold_req = 1'b1;
            goal = items_sent + RAND_PER_PHASE;
            while (items_sent < goal) begin
                if ($urandom_range(0, 9) < 8) begin
                    blob_sequence();
                end else begin
                    noise_item();
                end
            end
        end

        settle();
        if (paint_board.errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
